[rtl/core/hcpm_pkg.sv]
// shared types, constants and tables for the cosine-power hemisphere map
package hcpm_pkg;

    typedef struct packed {
        logic [15:0] sample_x;
        logic [15:0] sample_y;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] dir_u;
        logic signed [15:0] dir_v;
        logic [14:0]        dir_w;
    } t_out_word;

    // classified item handed from front end to back end
    typedef struct packed {
        logic [1:0]  quadrant;
        logic [13:0] residual;
        logic [15:0] sample_y;
    } t_job;

    localparam int AtanEntries = 24;
    localparam logic signed [33:0] CordicGainQ30 = 34'sd652032874;
    localparam logic [16:0] TwoPiQ14 = 17'd102944;
    localparam logic [63:0] OneQ30 = 64'd1 << 30;

    function automatic logic signed [33:0] atan_q30(input int k);
        logic signed [33:0] t;
        begin
            unique case (k)
                0: t = 34'sd843314857;
                1: t = 34'sd497837829;
                2: t = 34'sd263043837;
                3: t = 34'sd133525159;
                4: t = 34'sd67021687;
                5: t = 34'sd33543516;
                6: t = 34'sd16775851;
                7: t = 34'sd8388437;
                8: t = 34'sd4194283;
                9: t = 34'sd2097149;
                default: t = (k < AtanEntries) ? (34'sd1 << (30 - k)) : 34'sd0;
            endcase
            return t;
        end
    endfunction

    // 2^(-2^-k) in Q30, for k = 1..24 (floor square root chain from 0.5)
    function automatic logic [30:0] exp_factor(input int k);
        logic [63:0] c;
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] v;
        begin
            c = 64'd1 << 29;
            for (int i = 1; i <= 24; i++) begin
                if (i <= k) begin
                    v = c << 30;
                    rem = v;
                    res = 0;
                    bitv = 64'd1 << 62;
                    for (int j = 0; j < 32; j++) begin
                        if (bitv > v) bitv = bitv >> 2;
                    end
                    for (int j = 0; j < 32; j++) begin
                        if (bitv != 0) begin
                            if (rem >= res + bitv) begin
                                rem = rem - (res + bitv);
                                res = (res >> 1) + bitv;
                            end else begin
                                res = res >> 1;
                            end
                            bitv = bitv >> 2;
                        end
                    end
                    c = res;
                end
            end
            return c[30:0];
        end
    endfunction

endpackage

[rtl/core/hemisphere_cosine_power_map.sv]
// top level of the cosine-power hemisphere direction mapper
// One sample word is taken each cycle (busy never rises); its direction word
// appears with o_done after the front register and the cordic, log2 / divide /
// exp2 and square-root pipeline of the back end.
// The receiver cannot stall: every result is shown for exactly one cycle.
module hemisphere_cosine_power_map
    import hcpm_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_word    i_word,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output logic        o_done,
    output t_out_word   o_word
);

    logic [15:0] r_exponent;
    logic        w_valid;
    t_job        w_job;

    // exponent register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= '0;
        end else if (i_cfg_we) begin
            r_exponent <= i_cfg_data;
        end
    end

    assign busy = 1'b0;

    hcpm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (start && !busy),
        .i_word  (i_word),
        .o_valid (w_valid),
        .o_job   (w_job)
    );

    hcpm_back #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid),
        .i_job      (w_job),
        .i_exponent (r_exponent),
        .o_valid    (o_done),
        .o_word     (o_word)
    );

endmodule

[rtl/core/hcpm_front.sv]
// front end: accepts sample words, splits azimuth into quadrant and residual
module hcpm_front
    import hcpm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_take,
    input  t_in_word i_word,
    output logic     o_valid,
    output t_job     o_job
);

    logic r_valid;
    t_job r_job;

    // classify and register the incoming word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_take;
        end
        r_job.quadrant <= i_word.sample_x[15:14];
        r_job.residual <= i_word.sample_x[13:0];
        r_job.sample_y <= i_word.sample_y;
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;

endmodule

[rtl/core/hcpm_back.sv]
// back end: pipelined cordic, log2 / divide / exp2 and square-root datapath
module hcpm_back
    import hcpm_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_job        i_job,
    input  logic [15:0] i_exponent,
    output logic        o_valid,
    output t_out_word   o_word
);

    localparam int CS   = (CORDIC_STEPS < AtanEntries) ? CORDIC_STEPS : AtanEntries;
    localparam int FB   = FRAC_BITS;
    localparam int ZW   = FB + 2;
    localparam int AW   = FB + 5;
    localparam int BW   = AW + 1;
    localparam int QW   = AW + 9;
    localparam int DIVN = QW;
    localparam int S1   = 1;
    localparam int S_NORM = S1 + 1;
    localparam int S_SQ   = S_NORM + FB;
    localparam int S_DIV  = S_SQ + DIVN;
    localparam int S_EXP  = S_DIV + FB + 1;
    localparam int S_SQRT = S_EXP + 31;
    localparam int DEPTH  = S_SQRT + 3;

    // valid line through every stage
    logic [DEPTH-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    // ---------------- cordic: one rotation per stage, then a delay line
    logic signed [33:0] r_cx [0:CS];
    logic signed [33:0] r_cy [0:CS];
    logic signed [33:0] r_cz [0:CS];
    logic [1:0]         r_cq [0:CS];

    always_ff @(posedge i_clk) begin
        r_cx[0] <= CordicGainQ30;
        r_cy[0] <= '0;
        r_cz[0] <= 34'(34'(i_job.residual) * 34'(TwoPiQ14));
        r_cq[0] <= i_job.quadrant;
    end

    for (genvar g = 0; g < CS; g++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (!r_cz[g][33]) begin
                r_cx[g+1] <= r_cx[g] - (r_cy[g] >>> g);
                r_cy[g+1] <= r_cy[g] + (r_cx[g] >>> g);
                r_cz[g+1] <= r_cz[g] - atan_q30(g);
            end else begin
                r_cx[g+1] <= r_cx[g] + (r_cy[g] >>> g);
                r_cy[g+1] <= r_cy[g] - (r_cx[g] >>> g);
                r_cz[g+1] <= r_cz[g] + atan_q30(g);
            end
            r_cq[g+1] <= r_cq[g];
        end
    end

    // quadrant swap, then hold until the theta path catches up
    localparam int PHD = S_SQRT - CS;
    logic signed [31:0] r_cph [0:PHD];
    logic signed [31:0] r_sph [0:PHD];
    always_ff @(posedge i_clk) begin
        unique case (r_cq[CS])
            2'd0: begin r_cph[0] <= 32'(r_cx[CS]);  r_sph[0] <= 32'(r_cy[CS]);  end
            2'd1: begin r_cph[0] <= 32'(-r_cy[CS]); r_sph[0] <= 32'(r_cx[CS]);  end
            2'd2: begin r_cph[0] <= 32'(-r_cx[CS]); r_sph[0] <= 32'(-r_cy[CS]); end
            default: begin r_cph[0] <= 32'(r_cy[CS]); r_sph[0] <= 32'(-r_cx[CS]); end
        endcase
    end
    for (genvar g = 0; g < PHD; g++) begin : g_phd
        always_ff @(posedge i_clk) begin
            r_cph[g+1] <= r_cph[g];
            r_sph[g+1] <= r_sph[g];
        end
    end

    // ---------------- log2: normalize m = 65536 - y
    logic [16:0] w_m;
    logic [4:0]  w_n;
    assign w_m = 17'd65536 - {1'b0, i_job.sample_y};
    always_comb begin
        w_n = '0;
        for (int k = 0; k < 17; k++) begin
            if (w_m[k]) w_n = 5'(k);
        end
    end

    logic [ZW-1:0] r_z   [0:FB];
    logic [FB-1:0] r_fr  [0:FB];
    logic [4:0]    r_n   [0:FB];
    logic [15:0]   r_ex  [0:FB];

    always_ff @(posedge i_clk) begin
        if (w_n <= 5'(FB)) begin
            r_z[0] <= ZW'(48'(w_m) << (FB - int'(w_n)));
        end else begin
            r_z[0] <= ZW'(w_m >> (int'(w_n) - FB));
        end
        r_fr[0] <= '0;
        r_n[0]  <= w_n;
        r_ex[0] <= i_exponent;
    end

    // one square-and-compare per stage
    for (genvar g = 0; g < FB; g++) begin : g_log
        logic [2*ZW-1:0] w_sq;
        logic [ZW-1:0]   w_zs;
        assign w_sq = r_z[g] * r_z[g];
        assign w_zs = ZW'(w_sq >> FB);
        always_ff @(posedge i_clk) begin
            if (w_zs[ZW-1]) begin
                r_z[g+1]  <= w_zs >> 1;
                r_fr[g+1] <= r_fr[g] | (FB'(1) << (FB - 1 - g));
            end else begin
                r_z[g+1]  <= w_zs;
                r_fr[g+1] <= r_fr[g];
            end
            r_n[g+1]  <= r_n[g];
            r_ex[g+1] <= r_ex[g];
        end
    end

    // ---------------- restoring divide, one quotient bit per stage
    logic [QW-1:0] r_num [0:DIVN];
    logic [QW-1:0] r_rem [0:DIVN];
    logic [QW-1:0] r_quo [0:DIVN];
    logic [16:0]   r_den [0:DIVN];

    logic [AW-1:0] w_a;
    logic [16:0]   w_d;
    assign w_a = AW'((5'd16 - r_n[FB])) * (AW'(1) << FB) - AW'(r_fr[FB]);
    assign w_d = {1'b0, r_ex[FB]} + 17'd256;

    always_ff @(posedge i_clk) begin
        r_num[0] <= QW'({w_a, 8'd0}) + QW'(w_d >> 1);
        r_rem[0] <= '0;
        r_quo[0] <= '0;
        r_den[0] <= w_d;
    end

    for (genvar g = 0; g < DIVN; g++) begin : g_div
        logic [QW:0] w_tr;
        assign w_tr = {r_rem[g], r_num[g][QW-1-g]};
        always_ff @(posedge i_clk) begin
            if (w_tr >= (QW+1)'(r_den[g])) begin
                r_rem[g+1] <= QW'(w_tr - (QW+1)'(r_den[g]));
                r_quo[g+1] <= r_quo[g] | (QW'(1) << (QW - 1 - g));
            end else begin
                r_rem[g+1] <= QW'(w_tr);
                r_quo[g+1] <= r_quo[g];
            end
            r_num[g+1] <= r_num[g];
            r_den[g+1] <= r_den[g];
        end
    end

    // ---------------- exp2: one factor multiply per stage
    logic [30:0]    r_r  [0:FB];
    logic [FB-1:0]  r_fp [0:FB];
    logic           r_big[0:FB];
    logic [4:0]     r_ip [0:FB];

    always_ff @(posedge i_clk) begin
        r_r[0]   <= OneQ30[30:0];
        r_fp[0]  <= r_quo[DIVN][FB-1:0];
        r_big[0] <= (r_quo[DIVN] >> FB) >= QW'(31);
        r_ip[0]  <= 5'(r_quo[DIVN] >> FB);
    end

    for (genvar g = 0; g < FB; g++) begin : g_exp
        localparam logic [30:0] Fac = exp_factor(g + 1);
        logic [61:0] w_pr;
        assign w_pr = r_r[g] * Fac;
        always_ff @(posedge i_clk) begin
            if (r_fp[g][FB-1-g]) begin
                r_r[g+1] <= 31'(w_pr >> 30);
            end else begin
                r_r[g+1] <= r_r[g];
            end
            r_fp[g+1]  <= r_fp[g];
            r_big[g+1] <= r_big[g];
            r_ip[g+1]  <= r_ip[g];
        end
    end

    // shift by the integer part gives cos theta, then 1 - c^2
    logic [30:0] r_ct;
    logic [60:0] r_rad;
    logic [30:0] r_ct2;
    always_ff @(posedge i_clk) begin
        r_ct <= r_big[FB] ? 31'd0 : (r_r[FB] >> r_ip[FB]);
    end
    logic [61:0] w_ctsq;
    assign w_ctsq = r_ct * r_ct;

    // bit-serial square root, one result bit per stage
    logic [61:0] r_sr [0:30];
    logic [61:0] r_sq [0:30];
    logic [30:0] r_sc [0:30];
    always_ff @(posedge i_clk) begin
        r_sr[0] <= 62'(62'd1 << 60) - w_ctsq;
        r_sq[0] <= '0;
        r_sc[0] <= r_ct;
    end
    for (genvar g = 0; g < 30; g++) begin : g_sqrt
        localparam logic [61:0] Bit = 62'd1 << (60 - 2 * g);
        always_ff @(posedge i_clk) begin
            if (r_sr[g] >= r_sq[g] + Bit) begin
                r_sr[g+1] <= r_sr[g] - (r_sq[g] + Bit);
                r_sq[g+1] <= (r_sq[g] >> 1) + Bit;
            end else begin
                r_sr[g+1] <= r_sr[g];
                r_sq[g+1] <= r_sq[g] >> 1;
            end
            r_sc[g+1] <= r_sc[g];
        end
    end
    assign r_rad = r_sr[30][60:0];
    assign r_ct2 = r_sc[30];

    // final bit of the root and products
    logic [31:0] r_st;
    logic [30:0] r_ctf;
    always_ff @(posedge i_clk) begin
        if (r_sr[30] >= r_sq[30] + 62'd1) begin
            r_st <= 32'((r_sq[30] >> 1) + 62'd1);
        end else begin
            r_st <= 32'(r_sq[30] >> 1);
        end
        r_ctf <= r_ct2;
    end

    logic signed [64:0] w_pu;
    logic signed [64:0] w_pv;
    assign w_pu = $signed({1'b0, r_st}) * r_cph[PHD];
    assign w_pv = $signed({1'b0, r_st}) * r_sph[PHD];

    function automatic logic signed [15:0] sat16(input logic signed [64:0] p);
        logic signed [64:0] r;
        begin
            r = ((p >>> 30) + 65'sd16384) >>> 15;
            if (r > 65'sd32767) return 16'sd32767;
            if (r < -65'sd32768) return -16'sd32768;
            return 16'(r);
        end
    endfunction

    logic [31:0] w_wr;
    assign w_wr = (32'(r_ctf) + 32'd16384) >> 15;

    t_out_word r_out;
    always_ff @(posedge i_clk) begin
        r_out.dir_u <= sat16(w_pu);
        r_out.dir_v <= sat16(w_pv);
        r_out.dir_w <= (w_wr > 32'd32767) ? 15'd32767 : w_wr[14:0];
    end

    assign o_valid = r_vld[DEPTH-1];
    assign o_word  = r_out;

    logic w_unused;
    assign w_unused = ^r_rad ^ ^r_fr[FB] ^ ^r_z[FB] ^ ^r_ex[FB] ^ ^r_rem[DIVN]
                    ^ ^r_num[DIVN] ^ ^r_den[DIVN] ^ ^r_fp[FB] ^ ^r_cz[CS];

    // results only appear a fixed latency after an accepted job; dir_w stays in range
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> ##(DEPTH-1) o_valid) else $error("latency slip");
    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_vld[DEPTH-2])) else $error("spurious result");
    a_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_word.dir_w <= 15'd32767) else $error("cos range");

endmodule
